// ===== rtl/sdrd_pkg.sv =====
// Shared types and constants for the signed divider register device.
package sdrd_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  typedef enum logic [1:0] {
    CMD_STORE_DIVIDEND = 2'd0,
    CMD_STORE_DIVISOR  = 2'd1,
    CMD_DIVIDE         = 2'd2,
    CMD_RESET          = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX
  } state_t;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  function automatic logic [DATA_W-1:0] negate(input logic [DATA_W-1:0] v);
    negate = ~v + {{(DATA_W-1){1'b0}}, 1'b1};
  endfunction

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? negate(v) : v;
  endfunction

endpackage

// ===== rtl/signed_divider_register_device.sv =====
// Top level: 32-bit signed divider with dividend, divisor and result registers.
//
// Usage: each request on the in_ channel carries a command (store dividend,
// store divisor, divide, reset) and a value that only the store commands use.
// Every request yields exactly one response on the out_ channel, which shows
// the status and all registers as they stand after the command.
// Store and reset commands respond in the cycle after acceptance.
// Divide runs a radix-2 restoring divider, one quotient bit per cycle:
// the operands load at acceptance, then the iteration state ST_DIV shifts in
// one quotient bit per step and the sign fix-up state ST_FIX posts the response.
// A divide by a zero divisor responds in the cycle after acceptance with status 1 and
// leaves every register unchanged.
// One request is in flight at a time; in_ready is high while no divide runs
// and the response register is empty or being taken in the same cycle.
// While the receiver stalls, the response holds and no request is taken.
// After rst_n: dividend 0, divisor 1, quotient 0, remainder 0, synced 1,
// no response pending.
module signed_divider_register_device
  import sdrd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_status,
  output logic signed [DATA_W-1:0] out_dividend,
  output logic signed [DATA_W-1:0] out_divisor,
  output logic signed [DATA_W-1:0] out_quotient,
  output logic signed [DATA_W-1:0] out_remainder,
  output logic                     out_synced
);

  state_t              state_r, state_nxt;
  logic [DATA_W-1:0]   dividend_r, divisor_r, quotient_r, remainder_r;
  logic                sync_r;
  logic                status_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   quo_r;
  logic [DATA_W-1:0]   dvs_r;
  logic [CNT_W-1:0]    cnt_r;

  logic                in_fire;
  logic                out_fire;
  cmd_t                cmd;
  logic                div_zero;
  logic                div_start;
  logic                div_last;
  logic [DATA_W:0]     div_shift;
  logic [DATA_W:0]     div_trial;
  logic                q_bit;

  assign cmd      = cmd_t'(in_cmd);
  assign div_zero = (divisor_r == '0);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  assign div_shift = {rem_r, quo_r[DATA_W-1]};
  assign div_trial = div_shift - {1'b0, dvs_r};
  assign q_bit     = !div_trial[DATA_W];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_DIVIDE && !div_zero) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_last  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = !out_valid_r || out_ready;
        div_start = in_fire && cmd == CMD_DIVIDE && !div_zero;
      end
      ST_DIV: begin
        div_last = (cnt_r == CNT_W'(DATA_W - 1));
      end
      ST_FIX:  ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
      dividend_r  <= '0;
      divisor_r   <= {{(DATA_W-1){1'b0}}, 1'b1};
      quotient_r  <= '0;
      remainder_r <= '0;
      sync_r      <= 1'b1;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        case (cmd)
          CMD_STORE_DIVIDEND: begin
            status_r    <= STATUS_OK;
            dividend_r  <= in_value;
            sync_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end
          CMD_STORE_DIVISOR: begin
            status_r    <= STATUS_OK;
            divisor_r   <= in_value;
            sync_r      <= 1'b0;
            out_valid_r <= 1'b1;
          end
          CMD_DIVIDE: begin
            status_r    <= div_zero ? STATUS_DIV_ZERO : STATUS_OK;
            out_valid_r <= div_zero;
          end
          CMD_RESET: begin
            status_r    <= STATUS_OK;
            dividend_r  <= '0;
            divisor_r   <= {{(DATA_W-1){1'b0}}, 1'b1};
            quotient_r  <= '0;
            remainder_r <= '0;
            sync_r      <= 1'b1;
            out_valid_r <= 1'b1;
          end
          default: ;
        endcase
      end else if (state_r == ST_FIX) begin
        quotient_r  <= (dividend_r[DATA_W-1] != divisor_r[DATA_W-1]) ? negate(quo_r) : quo_r;
        remainder_r <= dividend_r[DATA_W-1] ? negate(rem_r) : rem_r;
        sync_r      <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (div_start) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      rem_r <= '0;
      quo_r <= magnitude(dividend_r);
      dvs_r <= magnitude(divisor_r);
    end else if (state_r == ST_DIV) begin
      rem_r <= q_bit ? div_trial[DATA_W-1:0] : div_shift[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], q_bit};
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_dividend  = dividend_r;
  assign out_divisor   = divisor_r;
  assign out_quotient  = quotient_r;
  assign out_remainder = remainder_r;
  assign out_synced    = sync_r;

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == ST_IDLE)
    else $error("request taken while divide in progress");

  a_no_resp_during_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> !out_valid_r)
    else $error("response pending during divide");

  a_fix_sets_sync: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIX |=> out_valid_r && sync_r && status_r == STATUS_OK)
    else $error("divide completion did not post synced response");

  a_zero_div_refused: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd == CMD_DIVIDE && div_zero |=>
      out_valid_r && status_r == STATUS_DIV_ZERO && $stable(quotient_r))
    else $error("zero divisor not refused");

endmodule
